// ===== rtl/wgm_pkg.sv =====
// Shared types, constants and helpers for the wrapped gradient map.
`default_nettype none

package wgm_pkg;

    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_W     = 16;
    localparam int GAIN_W       = 16;
    localparam int SAMPLE_IN_W  = 16;
    localparam int NARROW_BITS  = 8;
    localparam int COL_OUT_W    = 10;
    localparam int GRAD_W       = 8;
    localparam int GRAD_SHIFT   = 8;
    localparam int GRAD_BIAS    = 32768;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 16;

    localparam int DEF_MAX_WIDTH   = 1024;
    localparam int DEF_SAMPLE_BITS = 16;

    localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET  = 11'd1;
    localparam logic [HEIGHT_W-1:0]    HEIGHT_RESET = 16'd2;
    localparam logic [GAIN_W-1:0]      GAIN_RESET   = 16'd256;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_GAIN         = 2'd2,
        CFG_WIDE_SAMPLES = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [WIDTH_REG_W-1:0] image_width;
        logic [HEIGHT_W-1:0]    image_height;
        logic [GAIN_W-1:0]      gain;
        logic                   wide_samples;
    } cfg_t;

    typedef struct packed {
        logic row_above;
        logic last_row_left;
        logic last_row_end;
        logic col_zero;
        logic col_last;
        logic first_row;
    } item_flags_t;

    function automatic int col_bits(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/wgm_cfg_regs.sv =====
// Configuration registers of the wrapped gradient map.
`default_nettype none

module wgm_cfg_regs import wgm_pkg::*; (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                        cfg,
    output logic                        pos_clear
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next  = cfg_reg;
        pos_clear = 1'b0;
        if (cfg_we) begin
            case (cfg_index_t'(cfg_index))
                CFG_IMAGE_WIDTH: begin
                    cfg_next.image_width = cfg_data[WIDTH_REG_W-1:0];
                    pos_clear            = 1'b1;
                end
                CFG_IMAGE_HEIGHT: begin
                    cfg_next.image_height = cfg_data[HEIGHT_W-1:0];
                    pos_clear             = 1'b1;
                end
                CFG_GAIN: begin
                    cfg_next.gain = cfg_data[GAIN_W-1:0];
                end
                CFG_WIDE_SAMPLES: begin
                    cfg_next.wide_samples = cfg_data[0];
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.image_width  <= WIDTH_RESET;
            cfg_reg.image_height <= HEIGHT_RESET;
            cfg_reg.gain         <= GAIN_RESET;
            cfg_reg.wide_samples <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== rtl/wgm_fetch.sv =====
// Raster position counters, line stores and the input word register.
`default_nettype none

module wgm_fetch import wgm_pkg::*; #(
    parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire cfg_t                         cfg,
    input  wire logic                         pos_clear,
    input  wire logic                         accept,
    input  wire logic [SAMPLE_IN_W-1:0]       s_sample,
    output logic [col_bits(MAX_WIDTH)-1:0]    item_col,
    output logic [HEIGHT_W-1:0]               item_row,
    output logic [SAMPLE_BITS-1:0]            item_sample,
    output item_flags_t                       item_flags,
    output logic [SAMPLE_BITS-1:0]            prior_centre,
    output logic [SAMPLE_BITS-1:0]            prior_next,
    output logic [SAMPLE_BITS-1:0]            top_value
);

    localparam int COL_W  = col_bits(MAX_WIDTH);
    localparam int WCNT_W = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W  = (WCNT_W > WIDTH_REG_W) ? WCNT_W : WIDTH_REG_W;

    logic [SAMPLE_BITS-1:0] prior_mem [MAX_WIDTH];
    logic [SAMPLE_BITS-1:0] top_mem   [MAX_WIDTH];

    logic [CMP_W-1:0]       w_raw;
    logic [CMP_W-1:0]       w_eff;
    logic [HEIGHT_W-1:0]    h_eff;
    logic [COL_W-1:0]       col_reg;
    logic [COL_W-1:0]       col_next;
    logic [HEIGHT_W-1:0]    row_reg;
    logic [HEIGHT_W-1:0]    row_next;
    logic                   pos_wrap;
    logic [COL_W-1:0]       col_pos;
    logic [HEIGHT_W-1:0]    row_pos;
    logic                   col_last;
    logic                   row_last;
    logic [COL_W-1:0]       col_inc;
    logic [COL_W-1:0]       next_addr;
    logic [SAMPLE_BITS-1:0] sample_val;
    item_flags_t            flags_now;

    logic [COL_W-1:0]       item_col_reg;
    logic [HEIGHT_W-1:0]    item_row_reg;
    logic [SAMPLE_BITS-1:0] item_sample_reg;
    item_flags_t            item_flags_reg;
    logic [SAMPLE_BITS-1:0] prior_centre_reg;
    logic [SAMPLE_BITS-1:0] prior_next_reg;
    logic [SAMPLE_BITS-1:0] top_value_reg;

    always_comb begin
        w_raw = CMP_W'(cfg.image_width);
        if (w_raw == '0) begin
            w_eff = CMP_W'(1);
        end else if (w_raw > CMP_W'(MAX_WIDTH)) begin
            w_eff = CMP_W'(MAX_WIDTH);
        end else begin
            w_eff = w_raw;
        end
        h_eff = (cfg.image_height == '0) ? HEIGHT_W'(1) : cfg.image_height;
    end

    always_comb begin
        pos_wrap   = (CMP_W'(col_reg) >= w_eff) || (row_reg >= h_eff);
        col_pos    = pos_wrap ? '0 : col_reg;
        row_pos    = pos_wrap ? '0 : row_reg;
        col_last   = (CMP_W'(col_pos) == (w_eff - CMP_W'(1)));
        row_last   = (row_pos == (h_eff - HEIGHT_W'(1)));
        col_inc    = col_pos + COL_W'(1);
        next_addr  = col_last ? '0 : col_inc;
        sample_val = cfg.wide_samples ? s_sample[SAMPLE_BITS-1:0]
                                      : SAMPLE_BITS'(s_sample[NARROW_BITS-1:0]);

        flags_now.row_above     = (row_pos != '0);
        flags_now.last_row_left = row_last && (col_pos != '0);
        flags_now.last_row_end  = row_last && col_last;
        flags_now.col_zero      = (col_pos == '0);
        flags_now.col_last      = col_last;
        flags_now.first_row     = (row_pos == '0);
    end

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (pos_clear) begin
            col_next = '0;
            row_next = '0;
        end else if (accept) begin
            if (col_last) begin
                col_next = '0;
                row_next = row_last ? '0 : row_pos + HEIGHT_W'(1);
            end else begin
                col_next = col_inc;
                row_next = row_pos;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            prior_centre_reg   <= prior_mem[col_pos];
            prior_next_reg     <= prior_mem[next_addr];
            prior_mem[col_pos] <= sample_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            top_value_reg <= top_mem[col_pos];
            if (flags_now.first_row) begin
                top_mem[col_pos] <= sample_val;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_col_reg    <= col_pos;
            item_row_reg    <= row_pos;
            item_sample_reg <= sample_val;
            item_flags_reg  <= flags_now;
        end
    end

    assign item_col     = item_col_reg;
    assign item_row     = item_row_reg;
    assign item_sample  = item_sample_reg;
    assign item_flags   = item_flags_reg;
    assign prior_centre = prior_centre_reg;
    assign prior_next   = prior_next_reg;
    assign top_value    = top_value_reg;

endmodule

`default_nettype wire

// ===== rtl/wgm_emit.sv =====
// Result sequencing, gradient arithmetic and the output word register.
`default_nettype none

module wgm_emit import wgm_pkg::*; #(
    parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic [GAIN_W-1:0]            gain,
    input  wire logic                         accept,
    input  wire logic [col_bits(MAX_WIDTH)-1:0] item_col,
    input  wire logic [HEIGHT_W-1:0]          item_row,
    input  wire logic [SAMPLE_BITS-1:0]       item_sample,
    input  wire item_flags_t                  item_flags,
    input  wire logic [SAMPLE_BITS-1:0]       prior_centre,
    input  wire logic [SAMPLE_BITS-1:0]       prior_next,
    input  wire logic [SAMPLE_BITS-1:0]       top_value,
    input  wire logic                         m_ready,
    output logic                              s_ready,
    output logic                              item_valid,
    output logic                              m_valid,
    output logic [COL_OUT_W-1:0]              m_col,
    output logic [HEIGHT_W-1:0]               m_row_index,
    output logic [GRAD_W-1:0]                 m_horiz_grad,
    output logic [GRAD_W-1:0]                 m_vert_grad,
    output logic                              m_run_last
);

    localparam int COL_W  = col_bits(MAX_WIDTH);
    localparam int PROD_W = GAIN_W + SAMPLE_BITS + 1;
    localparam int SUM_W  = PROD_W + 1;

    localparam logic [2:0] RES_ABOVE = 3'b001;
    localparam logic [2:0] RES_LEFT  = 3'b010;
    localparam logic [2:0] RES_END   = 3'b100;

    function automatic logic [GRAD_W-1:0] grad_of(
        input logic signed [GAIN_W-1:0] g,
        input logic [SAMPLE_BITS-1:0]   nb,
        input logic [SAMPLE_BITS-1:0]   centre
    );
        logic signed [SAMPLE_BITS:0] diff;
        logic signed [PROD_W-1:0]    prod;
        logic signed [SUM_W-1:0]     t;
        logic [GRAD_W-1:0]           res;
        diff = $signed({1'b0, nb}) - $signed({1'b0, centre});
        prod = g * diff;
        t    = SUM_W'(prod) + SUM_W'(GRAD_BIAS);
        if (t[SUM_W-1]) begin
            res = '0;
        end else if (|t[SUM_W-2:GRAD_SHIFT+GRAD_W]) begin
            res = '1;
        end else begin
            res = t[GRAD_SHIFT +: GRAD_W];
        end
        return res;
    endfunction

    logic                   item_valid_reg;
    logic                   item_valid_next;
    logic [2:0]             done_reg;
    logic [2:0]             done_next;
    logic [SAMPLE_BITS-1:0] row_start_reg;
    logic [SAMPLE_BITS-1:0] row_start_next;
    logic [SAMPLE_BITS-1:0] prev_sample_reg;
    logic [SAMPLE_BITS-1:0] prev_sample_next;
    logic [SAMPLE_BITS-1:0] prev_top_reg;
    logic [SAMPLE_BITS-1:0] prev_top_next;
    logic                   m_valid_reg;
    logic                   m_valid_next;
    logic [COL_OUT_W-1:0]   m_col_reg;
    logic [HEIGHT_W-1:0]    m_row_reg;
    logic [GRAD_W-1:0]      m_horiz_reg;
    logic [GRAD_W-1:0]      m_vert_reg;
    logic                   m_last_reg;

    logic [2:0]             mask;
    logic [2:0]             pending;
    logic [2:0]             sel;
    logic                   final_pick;
    logic                   word_free;
    logic                   out_load;
    logic                   item_done;
    logic [SAMPLE_BITS-1:0] top_cur;
    logic [SAMPLE_BITS-1:0] op_centre;
    logic [SAMPLE_BITS-1:0] op_right;
    logic [SAMPLE_BITS-1:0] op_below;
    logic [COL_W-1:0]       op_col;
    logic [HEIGHT_W-1:0]    op_row;

    always_comb begin
        mask       = {item_flags.last_row_end, item_flags.last_row_left, item_flags.row_above};
        pending    = mask & ~done_reg;
        sel        = pending & (~pending + 3'd1);
        final_pick = (pending == sel);
        word_free  = !m_valid_reg || m_ready;
        out_load   = item_valid_reg && (pending != '0) && word_free;
        item_done  = item_valid_reg && ((pending == '0) || (out_load && final_pick));
        s_ready    = !item_valid_reg || item_done;
        top_cur    = item_flags.first_row ? item_sample : top_value;
    end

    always_comb begin
        op_centre = item_sample;
        op_right  = item_sample;
        op_below  = item_sample;
        op_col    = item_col;
        op_row    = item_row;
        case (sel)
            RES_ABOVE: begin
                op_centre = prior_centre;
                if (!item_flags.col_last) begin
                    op_right = prior_next;
                end else if (item_flags.col_zero) begin
                    op_right = prior_centre;
                end else begin
                    op_right = row_start_reg;
                end
                op_below = item_sample;
                op_row   = item_row - HEIGHT_W'(1);
            end
            RES_LEFT: begin
                op_centre = prev_sample_reg;
                op_right  = item_sample;
                op_below  = prev_top_reg;
                op_col    = item_col - COL_W'(1);
            end
            RES_END: begin
                op_centre = item_sample;
                op_right  = item_flags.col_zero ? item_sample : prior_next;
                op_below  = top_cur;
            end
            default: begin
                op_centre = item_sample;
            end
        endcase
    end

    always_comb begin
        item_valid_next  = accept ? 1'b1 : (item_done ? 1'b0 : item_valid_reg);
        done_next        = done_reg;
        if (accept) begin
            done_next = '0;
        end else if (out_load) begin
            done_next = done_reg | sel;
        end
        row_start_next   = row_start_reg;
        prev_sample_next = prev_sample_reg;
        prev_top_next    = prev_top_reg;
        if (item_done) begin
            prev_sample_next = item_sample;
            prev_top_next    = top_cur;
            if (item_flags.col_zero) begin
                row_start_next = prior_centre;
            end
        end
        m_valid_next = out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg  <= 1'b0;
            done_reg        <= '0;
            row_start_reg   <= '0;
            prev_sample_reg <= '0;
            prev_top_reg    <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            item_valid_reg  <= item_valid_next;
            done_reg        <= done_next;
            row_start_reg   <= row_start_next;
            prev_sample_reg <= prev_sample_next;
            prev_top_reg    <= prev_top_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_col_reg   <= COL_OUT_W'(op_col);
            m_row_reg   <= op_row;
            m_horiz_reg <= grad_of($signed(gain), op_right, op_centre);
            m_vert_reg  <= grad_of($signed(gain), op_below, op_centre);
            m_last_reg  <= final_pick;
        end
    end

    assign item_valid   = item_valid_reg;
    assign m_valid      = m_valid_reg;
    assign m_col        = m_col_reg;
    assign m_row_index  = m_row_reg;
    assign m_horiz_grad = m_horiz_reg;
    assign m_vert_grad  = m_vert_reg;
    assign m_run_last   = m_last_reg;

endmodule

`default_nettype wire

// ===== rtl/wrapped_gradient_map.sv =====
// Top level of the wrapped forward-difference gradient map.
//
// Samples enter in raster order on the s_ channel, one word per accepted
// handshake. Gradient words leave on the m_ channel, each carrying its column,
// row, horizontal and vertical gradient, and a flag marking the final word
// caused by one input sample.
// The first word for a sample is loaded into the output register after the
// sample has been held in the item register. Row 0 produces no words unless
// it is also the last row; each later row produces the words for the row
// above it. The last row produces up to two words per sample (three at its
// last column), because it also emits its own results against row 0.
// A sample is taken every cycle while one word per sample is due and m_ready
// is high; on the last row the rate is one output word per cycle, set by the
// single output register. The input and output registers are separate, so a
// new sample is taken while a finished word waits; when the receiver stalls,
// s_ready drops once the held sample still has words to deliver.
// Reset clears the configuration to its defaults and the position to the
// start of a frame; the line stores hold no contents until row 0 writes them.
// Writing the width or height restarts the frame at the next sample.
`default_nettype none

module wrapped_gradient_map import wgm_pkg::*; #(
    parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [SAMPLE_IN_W-1:0] s_sample,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [COL_OUT_W-1:0]        m_col,
    output logic [HEIGHT_W-1:0]         m_row_index,
    output logic [GRAD_W-1:0]           m_horiz_grad,
    output logic [GRAD_W-1:0]           m_vert_grad,
    output logic                        m_run_last,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int COL_W = col_bits(MAX_WIDTH);

    cfg_t                   cfg;
    logic                   pos_clear;
    logic                   accept;
    logic [COL_W-1:0]       item_col;
    logic [HEIGHT_W-1:0]    item_row;
    logic [SAMPLE_BITS-1:0] item_sample;
    item_flags_t            item_flags;
    logic [SAMPLE_BITS-1:0] prior_centre;
    logic [SAMPLE_BITS-1:0] prior_next;
    logic [SAMPLE_BITS-1:0] top_value;
    logic                   item_valid;

    assign accept = s_valid && s_ready;

    wgm_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .pos_clear (pos_clear)
    );

    wgm_fetch #(
        .MAX_WIDTH   (MAX_WIDTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_fetch (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .pos_clear    (pos_clear),
        .accept       (accept),
        .s_sample     (s_sample),
        .item_col     (item_col),
        .item_row     (item_row),
        .item_sample  (item_sample),
        .item_flags   (item_flags),
        .prior_centre (prior_centre),
        .prior_next   (prior_next),
        .top_value    (top_value)
    );

    wgm_emit #(
        .MAX_WIDTH   (MAX_WIDTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_emit (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .gain         (cfg.gain),
        .accept       (accept),
        .item_col     (item_col),
        .item_row     (item_row),
        .item_sample  (item_sample),
        .item_flags   (item_flags),
        .prior_centre (prior_centre),
        .prior_next   (prior_next),
        .top_value    (top_value),
        .m_ready      (m_ready),
        .s_ready      (s_ready),
        .item_valid   (item_valid),
        .m_valid      (m_valid),
        .m_col        (m_col),
        .m_row_index  (m_row_index),
        .m_horiz_grad (m_horiz_grad),
        .m_vert_grad  (m_vert_grad),
        .m_run_last   (m_run_last)
    );

    a_accept_holds_item: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> item_valid)
        else $error("accepted word did not reach the working register");

    a_word_from_item: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(item_valid))
        else $error("output word appeared without a held sample");

    a_more_words_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_run_last) |-> item_valid)
        else $error("non-final word shown but its sample has left");

endmodule

`default_nettype wire
